// File: rtl/cia402_seq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cia402_seq_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int DELAY_WIDTH    = 11;
  localparam int LIMIT_WIDTH    = 10;
  localparam int MODE_WIDTH     = 8;
  localparam int STEP_WIDTH     = 32;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_POSITION_STEP     = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FAULT_RESET_LIMIT = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_OPERATION_MODE    = 2'd2;

  localparam logic [STEP_WIDTH-1:0]  STEP_RESET  = 32'd10;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 10'd100;
  localparam logic [MODE_WIDTH-1:0]  MODE_RESET  = 8'd1;

  localparam logic [DELAY_WIDTH-1:0] DELAY_MAX = '1;

  localparam logic [15:0] CW_DISABLE      = 16'h0000;
  localparam logic [15:0] CW_FAULT_RESET  = 16'h0080;
  localparam logic [15:0] CW_SHUTDOWN     = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON    = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP    = 16'h000F;
  localparam logic [15:0] CW_NEW_SETPOINT = 16'h003F;

  localparam logic [15:0] SW_FAULT          = 16'h0008;
  localparam logic [15:0] SW_STATE_MASK     = 16'h006F;
  localparam logic [15:0] SW_READY          = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON    = 16'h0023;
  localparam logic [15:0] SW_OP_ENABLED     = 16'h0027;
  localparam logic [15:0] SW_TARGET_REACHED = 16'h0400;

  typedef struct packed {
    logic        command_valid;
    logic [2:0]  phase_out;
    logic [7:0]  mode_out;
    logic [31:0] target_position;
    logic [15:0] control_word;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/cia402_enable_and_step_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// CiA402 enable-and-step sequencer, master side.
// Input stream (s_*): one beat per bus cycle with the drive's status word and
// actual position; tuser carries the stop action and the process-data flag.
// Output stream (m_*): one beat per input beat with control word, target
// position, mode of operation and the phase reached; tuser carries
// command_valid.
// Config port: cfg_we / cfg_index / cfg_data, to be written by the user only
// while idle; the block itself does not enforce it. The result beat is
// registered. Throughput: one beat per cycle while m_tready is high; the
// whole decision is a few masks, compares and one 32-bit add, combinational.
// Reset: phase fault reset, counters and targets cleared, config back to
// step 10, limit 100, mode 1, output stream empty.
// Stall: a one-beat skid register takes one more beat while m_tready is low;
// after that s_tready stays low until the next output beat is taken.
module cia402_enable_and_step_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [15:0] status_word, [47:16] actual_position
  input  wire logic [47:0] s_tdata,
  // [0] action, [1] pdo_present
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [15:0] control_word, [47:16] target_position, [55:48] mode_out,
  // [58:56] phase_out, [63:59] zero
  output logic [63:0]      m_tdata,
  // [0] command_valid
  output logic [0:0]       m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [cia402_seq_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_FAULT_RESET = 3'd0,
    PH_SHUTDOWN    = 3'd1,
    PH_SWITCH_ON   = 3'd2,
    PH_ENABLE      = 3'd3,
    PH_RUNNING     = 3'd4
  } phase_t;

  localparam int PW = cia402_seq_pkg::POSITION_WIDTH;
  localparam int DW = cia402_seq_pkg::DELAY_WIDTH;

  logic [cia402_seq_pkg::STEP_WIDTH-1:0]  position_step;
  logic [cia402_seq_pkg::LIMIT_WIDTH-1:0] fault_reset_limit;
  logic [cia402_seq_pkg::MODE_WIDTH-1:0]  operation_mode;

  phase_t          phase, phase_next;
  logic [DW-1:0]   phase_delay, phase_delay_next;
  logic [PW-1:0]   target_accum, target_accum_next;
  logic            setpoint_pending, setpoint_pending_next;
  logic [PW-1:0]   sent_target, sent_target_next;

  cia402_seq_pkg::result_t result_next, out_reg, skid_reg;
  logic out_valid, skid_valid;

  logic        action, pdo_present, accept;
  logic [15:0] status_word, status_state;
  logic signed [31:0] actual_position;
  logic [DW-1:0] delay_inc;
  logic [15:0]   cw;

  assign action          = s_tuser[0];
  assign pdo_present     = s_tuser[1];
  assign status_word     = s_tdata[15:0];
  assign actual_position = s_tdata[47:16];
  assign status_state    = status_word & cia402_seq_pkg::SW_STATE_MASK;
  assign delay_inc       = (phase_delay == cia402_seq_pkg::DELAY_MAX) ?
                           phase_delay : phase_delay + DW'(1);

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_step     <= cia402_seq_pkg::STEP_RESET;
      fault_reset_limit <= cia402_seq_pkg::LIMIT_RESET;
      operation_mode    <= cia402_seq_pkg::MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cia402_seq_pkg::CFG_POSITION_STEP:
          position_step <= cfg_data;
        cia402_seq_pkg::CFG_FAULT_RESET_LIMIT:
          fault_reset_limit <= cfg_data[cia402_seq_pkg::LIMIT_WIDTH-1:0];
        cia402_seq_pkg::CFG_OPERATION_MODE:
          operation_mode <= cfg_data[cia402_seq_pkg::MODE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next            = phase;
    phase_delay_next      = phase_delay;
    target_accum_next     = target_accum;
    setpoint_pending_next = setpoint_pending;
    sent_target_next      = sent_target;
    cw                    = cia402_seq_pkg::CW_DISABLE;

    if (action) begin
      phase_next            = PH_FAULT_RESET;
      phase_delay_next      = '0;
      setpoint_pending_next = 1'b0;
    end else if (pdo_present) begin
      case (phase)
        PH_SHUTDOWN: begin
          cw = cia402_seq_pkg::CW_SHUTDOWN;
          if (status_state == cia402_seq_pkg::SW_READY) begin
            phase_next        = PH_SWITCH_ON;
            phase_delay_next  = '0;
            target_accum_next = PW'(actual_position);
          end
        end
        PH_SWITCH_ON: begin
          cw               = cia402_seq_pkg::CW_SWITCH_ON;
          sent_target_next = target_accum;
          if (status_state == cia402_seq_pkg::SW_SWITCHED_ON) begin
            phase_next       = PH_ENABLE;
            phase_delay_next = '0;
          end
        end
        PH_ENABLE: begin
          cw               = cia402_seq_pkg::CW_ENABLE_OP;
          sent_target_next = target_accum;
          if (status_state == cia402_seq_pkg::SW_OP_ENABLED) begin
            phase_next            = PH_RUNNING;
            phase_delay_next      = '0;
            setpoint_pending_next = 1'b0;
          end
        end
        PH_RUNNING: begin
          if (!setpoint_pending) begin
            target_accum_next     = target_accum + PW'(signed'(position_step));
            sent_target_next      = target_accum_next;
            cw                    = cia402_seq_pkg::CW_NEW_SETPOINT;
            setpoint_pending_next = 1'b1;
          end else if ((status_word & cia402_seq_pkg::SW_TARGET_REACHED) != '0) begin
            cw                    = cia402_seq_pkg::CW_ENABLE_OP;
            setpoint_pending_next = 1'b0;
          end else begin
            cw = cia402_seq_pkg::CW_NEW_SETPOINT;
          end
        end
        default: begin
          // fault reset, also any stray phase code
          phase_next       = PH_FAULT_RESET;
          cw               = ((status_word & cia402_seq_pkg::SW_FAULT) != '0) ?
                             cia402_seq_pkg::CW_FAULT_RESET : cia402_seq_pkg::CW_DISABLE;
          phase_delay_next = delay_inc;
          if ((delay_inc > DW'(fault_reset_limit)) ||
              ((status_word & cia402_seq_pkg::SW_FAULT) == '0)) begin
            phase_next       = PH_SHUTDOWN;
            phase_delay_next = '0;
          end
        end
      endcase
    end

    result_next.command_valid   = pdo_present;
    result_next.control_word    = cw;
    result_next.target_position = 32'(sent_target_next);
    result_next.mode_out        = operation_mode;
    result_next.phase_out       = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_FAULT_RESET;
      phase_delay      <= '0;
      target_accum     <= '0;
      setpoint_pending <= 1'b0;
      sent_target      <= '0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        phase_delay      <= phase_delay_next;
        target_accum     <= target_accum_next;
        setpoint_pending <= setpoint_pending_next;
        sent_target      <= sent_target_next;
      end
      if (out_valid && m_tready) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end else if (accept) begin
          out_reg <= result_next;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        if (accept) begin
          out_reg   <= result_next;
          out_valid <= 1'b1;
        end
      end else if (accept) begin
        skid_reg   <= result_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_reg.phase_out, out_reg.mode_out,
                     out_reg.target_position, out_reg.control_word};
  assign m_tuser  = out_reg.command_valid;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat held without an output beat");

  a_pending_only_running: assert property (@(posedge clk) disable iff (rst)
    setpoint_pending |-> (phase == PH_RUNNING))
    else $error("setpoint pending outside running phase");

  a_delay_only_fault_reset: assert property (@(posedge clk) disable iff (rst)
    (phase_delay != '0) |-> (phase == PH_FAULT_RESET))
    else $error("phase delay counting outside fault reset");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid))
    else $error("output not empty after reset");

endmodule

`default_nettype wire

// File: bench/cia402_command_checker.sv
`timescale 1ns / 1ps

module cia402_command_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [47:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,
  input  wire logic [0:0]  m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [cia402_seq_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               mismatches,
  output int               results_due,
  output int               results_checked,
  output logic [4:0]       phases_reached
);

  typedef enum logic [2:0] {
    PH_FAULT_RESET = 3'd0,
    PH_SHUTDOWN    = 3'd1,
    PH_SWITCH_ON   = 3'd2,
    PH_ENABLE      = 3'd3,
    PH_RUNNING     = 3'd4
  } phase_e;

  logic [cia402_seq_pkg::STEP_WIDTH-1:0]     step_reg;
  logic [cia402_seq_pkg::LIMIT_WIDTH-1:0]    limit_reg;
  logic [cia402_seq_pkg::MODE_WIDTH-1:0]     mode_reg;

  phase_e                                    phase;
  logic [cia402_seq_pkg::DELAY_WIDTH-1:0]    fault_wait;
  logic [cia402_seq_pkg::POSITION_WIDTH-1:0] target_sum;
  logic                                      setpoint_open;
  logic [cia402_seq_pkg::POSITION_WIDTH-1:0] target_held;

  cia402_seq_pkg::result_t commands_due[$];
  int      mismatch_total = 0;
  int      checked_total = 0;
  logic [4:0] phase_mask = '0;

  function automatic cia402_seq_pkg::result_t next_command(input logic stop,
                                                           input logic present,
                                                           input logic [15:0] sw,
                                                           input logic [31:0] pos);
    cia402_seq_pkg::result_t r;
    r = '0;
    if (stop) begin
      r.command_valid = present;
      r.control_word = cia402_seq_pkg::CW_DISABLE;
      phase = PH_FAULT_RESET;
      fault_wait = '0;
      setpoint_open = 1'b0;
    end else if (present) begin
      r.command_valid = 1'b1;
      case (phase)
        PH_SHUTDOWN: begin
          r.control_word = cia402_seq_pkg::CW_SHUTDOWN;
          if ((sw & cia402_seq_pkg::SW_STATE_MASK) == cia402_seq_pkg::SW_READY) begin
            phase = PH_SWITCH_ON;
            fault_wait = '0;
            target_sum = pos;
          end
        end
        PH_SWITCH_ON: begin
          r.control_word = cia402_seq_pkg::CW_SWITCH_ON;
          target_held = target_sum;
          if ((sw & cia402_seq_pkg::SW_STATE_MASK) == cia402_seq_pkg::SW_SWITCHED_ON) begin
            phase = PH_ENABLE;
            fault_wait = '0;
          end
        end
        PH_ENABLE: begin
          r.control_word = cia402_seq_pkg::CW_ENABLE_OP;
          target_held = target_sum;
          if ((sw & cia402_seq_pkg::SW_STATE_MASK) == cia402_seq_pkg::SW_OP_ENABLED) begin
            phase = PH_RUNNING;
            fault_wait = '0;
            setpoint_open = 1'b0;
          end
        end
        PH_RUNNING: begin
          if (!setpoint_open) begin
            target_sum = target_sum + step_reg;
            target_held = target_sum;
            r.control_word = cia402_seq_pkg::CW_NEW_SETPOINT;
            setpoint_open = 1'b1;
          end else if ((sw & cia402_seq_pkg::SW_TARGET_REACHED) != 16'h0) begin
            r.control_word = cia402_seq_pkg::CW_ENABLE_OP;
            setpoint_open = 1'b0;
          end else begin
            r.control_word = cia402_seq_pkg::CW_NEW_SETPOINT;
          end
        end
        default: begin
          phase = PH_FAULT_RESET;
          r.control_word = ((sw & cia402_seq_pkg::SW_FAULT) != 16'h0) ?
                           cia402_seq_pkg::CW_FAULT_RESET : cia402_seq_pkg::CW_DISABLE;
          if (fault_wait != cia402_seq_pkg::DELAY_MAX)
            fault_wait = fault_wait + cia402_seq_pkg::DELAY_WIDTH'(1);
          if (fault_wait > {1'b0, limit_reg} || (sw & cia402_seq_pkg::SW_FAULT) == 16'h0) begin
            phase = PH_SHUTDOWN;
            fault_wait = '0;
          end
        end
      endcase
    end
    r.target_position = target_held;
    r.mode_out = mode_reg;
    r.phase_out = phase;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    cia402_seq_pkg::result_t want;
    if (rst) begin
      step_reg = cia402_seq_pkg::STEP_RESET;
      limit_reg = cia402_seq_pkg::LIMIT_RESET;
      mode_reg = cia402_seq_pkg::MODE_RESET;
      phase = PH_FAULT_RESET;
      fault_wait = '0;
      target_sum = '0;
      setpoint_open = 1'b0;
      target_held = '0;
      commands_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cia402_seq_pkg::CFG_POSITION_STEP:
            step_reg = cfg_data;
          cia402_seq_pkg::CFG_FAULT_RESET_LIMIT:
            limit_reg = cfg_data[cia402_seq_pkg::LIMIT_WIDTH-1:0];
          cia402_seq_pkg::CFG_OPERATION_MODE:
            mode_reg = cfg_data[cia402_seq_pkg::MODE_WIDTH-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (commands_due.size() == 0) begin
          $error("result beat with nothing expected: control_word %h target %h",
                 m_tdata[15:0], m_tdata[47:16]);
          mismatch_total++;
        end else begin
          want = commands_due.pop_front();
          compare_field("command_valid", 32'(want.command_valid), 32'(m_tuser[0]));
          compare_field("control_word", 32'(want.control_word), 32'(m_tdata[15:0]));
          compare_field("target_position", want.target_position, m_tdata[47:16]);
          compare_field("mode_out", 32'(want.mode_out), 32'(m_tdata[55:48]));
          compare_field("phase_out", 32'(want.phase_out), 32'(m_tdata[58:56]));
          checked_total++;
        end
      end
      if (s_tvalid && s_tready) begin
        want = next_command(s_tuser[0], s_tuser[1], s_tdata[15:0], s_tdata[47:16]);
        phase_mask[want.phase_out] = 1'b1;
        commands_due.push_back(want);
      end
    end
    mismatches <= mismatch_total;
    results_due <= commands_due.size();
    results_checked <= checked_total;
    phases_reached <= phase_mask;
  end

endmodule

// File: bench/cia402_enable_and_step_sequencer_unit_tb.sv
`timescale 1ns / 1ps

module cia402_enable_and_step_sequencer_unit_tb;

  localparam int QUIET_LIMIT = 1500;
  localparam int HOLD_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [cia402_seq_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int         mismatch_count;
  int         results_due;
  int         results_checked;
  logic [4:0] phases_reached;

  bit steady = 1'b0;
  int hold_requests = 0;
  int beats_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  cia402_enable_and_step_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cia402_command_checker cmd_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatch_count), .results_due(results_due),
    .results_checked(results_checked), .phases_reached(phases_reached)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned idle_len(input int unsigned zero_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < zero_pct + (100 - zero_pct) * 3 / 4) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  initial begin : sink
    int stall_left;
    int holds_served;
    stall_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady) begin
        stall_left = idle_len(75);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("cia402_enable_and_step_sequencer_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_position();
    case ($urandom_range(0, 11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] state_word(input logic [15:0] code);
    return (16'($urandom) & ~cia402_seq_pkg::SW_STATE_MASK) | code;
  endfunction

  function automatic logic [15:0] miss_word(input logic [15:0] code);
    logic [15:0] w;
    w = 16'($urandom);
    if ((w & cia402_seq_pkg::SW_STATE_MASK) == code) w ^= 16'h0001;
    return w;
  endfunction

  task automatic push_beat(input logic stop, input logic present, input logic [15:0] sw,
                           input logic [31:0] pos);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= {pos, sw};
    s_tuser <= {present, stop};
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    gap = steady ? 0 : idle_len(65);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // intended status beat, sometimes preceded by an absent beat or noise
  task automatic offer(input logic [15:0] sw);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      push_beat(1'b0, 1'b0, sw, pick_position());
    end else if (r < 10) begin
      push_beat($urandom_range(0, 19) == 0, $urandom_range(0, 3) != 0, 16'($urandom),
                pick_position());
    end
    push_beat(1'b0, 1'b1, sw, pick_position());
  endtask

  task automatic drive_sequence(input int fault_n, input int run_n);
    push_beat(1'b1, 1'($urandom_range(0, 1)), 16'($urandom), pick_position());
    repeat (fault_n) offer(16'($urandom) | cia402_seq_pkg::SW_FAULT);
    offer(state_word(cia402_seq_pkg::SW_READY));
    repeat ($urandom_range(0, 2)) offer(miss_word(cia402_seq_pkg::SW_READY));
    offer(state_word(cia402_seq_pkg::SW_READY));
    repeat ($urandom_range(0, 2)) offer(miss_word(cia402_seq_pkg::SW_SWITCHED_ON));
    offer(state_word(cia402_seq_pkg::SW_SWITCHED_ON));
    repeat ($urandom_range(0, 2)) offer(miss_word(cia402_seq_pkg::SW_OP_ENABLED));
    offer(state_word(cia402_seq_pkg::SW_OP_ENABLED));
    repeat (run_n) begin
      if ($urandom_range(0, 99) < 40)
        offer(16'($urandom) | cia402_seq_pkg::SW_TARGET_REACHED);
      else
        offer(16'($urandom) & ~cia402_seq_pkg::SW_TARGET_REACHED);
    end
  endtask

  task automatic run_random(input int n, input int fault_hi);
    int stop_at;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        drive_sequence($urandom_range(0, fault_hi), $urandom_range(4, 24));
      end else begin
        repeat ($urandom_range(3, 12))
          push_beat($urandom_range(0, 99) < 15, $urandom_range(0, 3) != 0,
                    16'($urandom), pick_position());
      end
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cia402_seq_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] step, input logic [31:0] limit,
                                input logic [31:0] mode);
    settle();
    write_reg(cia402_seq_pkg::CFG_POSITION_STEP, step);
    write_reg(cia402_seq_pkg::CFG_FAULT_RESET_LIMIT, limit);
    write_reg(cia402_seq_pkg::CFG_OPERATION_MODE, mode);
    settings_used++;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: walk every phase by hand
    push_beat(1'b0, 1'b0, 16'hFFFF, 32'h7FFF_FFFF);
    push_beat(1'b1, 1'b0, 16'h0000, 32'h0000_0000);
    push_beat(1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_FAULT, 32'h0000_0000);
    push_beat(1'b0, 1'b1, 16'hFFFF, 32'h8000_0000);
    push_beat(1'b0, 1'b1, 16'h0000, 32'h1234_5678);
    push_beat(1'b0, 1'b1, 16'h0000, 32'h0000_0000);
    push_beat(1'b0, 1'b0, cia402_seq_pkg::SW_READY, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_READY | 16'hFF90, 32'h7FFF_FFFF);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_READY, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_SWITCHED_ON, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_SWITCHED_ON, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_OP_ENABLED, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_OP_ENABLED, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_OP_ENABLED, 32'h0000_0000);
    push_beat(1'b0, 1'b0, cia402_seq_pkg::SW_TARGET_REACHED, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_TARGET_REACHED | cia402_seq_pkg::SW_OP_ENABLED,
              32'h0000_0000);
    push_beat(1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    push_beat(1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    push_beat(1'b1, 1'b1, 16'h0000, 32'h0000_0000);
    push_beat(1'b0, 1'b1, 16'h0000, 32'h0000_0000);
    push_beat(1'b0, 1'b1, cia402_seq_pkg::SW_READY, 32'h8000_0000);
    push_beat(1'b1, 1'b0, 16'h0000, 32'h0000_0000);

    apply_settings(32'h7FFF_FFFF, 32'd0, 32'd255);
    run_random(60, 3);

    // upper data bits above the limit field are dropped: limit becomes 3
    apply_settings(32'h8000_0000, 32'hFFFF_FC03, 32'd0);
    hold_requests++;
    steady = 1'b1;
    drive_sequence(2, 24);
    steady = 1'b0;
    run_random(60, 6);

    apply_settings($urandom, $urandom_range(1, 12), $urandom_range(0, 255));
    steady = 1'b1;
    run_random(30, 8);
    steady = 1'b0;
    run_random(50, 10);

    // fault reset runs out its count once
    apply_settings(32'hFFFF_FFFF, 32'd20, 32'd1);
    drive_sequence(24, 10);
    run_random(40, 3);

    apply_settings(32'h0000_0000, 32'd5, 32'h0000_0080);
    run_random(60, 8);

    settle();
    $display("Drove %0d input beats under %0d register settings plus reset values;",
             beats_sent, settings_used);
    $display("%0d results compared, phases seen %b, one %0d-cycle receiver hold-off.",
             results_checked, phases_reached, HOLD_CYCLES);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("cia402_enable_and_step_sequencer_unit verification clean");
    end else begin
      $display("cia402_enable_and_step_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule

// File: cia402_enable_and_step_sequencer_unit.f
rtl/cia402_seq_pkg.sv
rtl/cia402_enable_and_step_sequencer_unit.sv
bench/cia402_command_checker.sv
bench/cia402_enable_and_step_sequencer_unit_tb.sv
